// ===== rtl/stu_pkg.sv =====
package stu_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned OUT_VALUE_W = 64;
    localparam int unsigned OUT_COUNT_W = 16;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [CODE_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CODE_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CODE_W-1:0] CHAR_UP_X  = 8'h58;
    localparam logic [CODE_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CODE_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CODE_W-1:0] CHAR_LO_X  = 8'h78;
    localparam logic [CODE_W-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [CODE_W-1:0] LETTER_BIAS = 8'd10;

    localparam logic [ADDR_W-3:0] REG_NUMBER_BASE = 1'b0;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_X,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              is_last;
    } char_word_t;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic [OUT_COUNT_W-1:0] consumed_count;
    } result_word_t;

    typedef struct packed {
        logic               is_last;
        logic               is_space;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } class_word_t;

endpackage

// ===== rtl/stu_front.sv =====
module stu_front
    import stu_pkg::*;
(
    input  logic        char_valid,
    output logic        char_ready,
    input  char_word_t  char_word,
    input  logic        queue_full,
    output logic        push,
    output class_word_t push_word
);

    logic [CODE_W-1:0] code;

    assign code       = char_word.char_code;
    assign char_ready = !queue_full;
    assign push       = char_valid && !queue_full;

    always_comb
    begin
        push_word          = '0;
        push_word.is_last  = char_word.is_last;
        push_word.is_space = code inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_FF,
                                          CHAR_VT};
        push_word.is_plus  = (code == CHAR_PLUS);
        push_word.is_zero  = (code == CHAR_ZERO);
        push_word.is_x     = (code == CHAR_LO_X) || (code == CHAR_UP_X);
        if (code inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            push_word.is_digit = 1'b1;
            push_word.digit    = DIGIT_W'(code - CHAR_ZERO);
        end
        else if (code inside {[CHAR_LO_A:CHAR_LO_Z]})
        begin
            push_word.is_digit = 1'b1;
            push_word.digit    = DIGIT_W'(code - CHAR_LO_A + LETTER_BIAS);
        end
        else if (code inside {[CHAR_UP_A:CHAR_UP_Z]})
        begin
            push_word.is_digit = 1'b1;
            push_word.digit    = DIGIT_W'(code - CHAR_UP_A + LETTER_BIAS);
        end
    end

endmodule

// ===== rtl/stu_queue.sv =====
module stu_queue
    import stu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  class_word_t push_word,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output class_word_t pop_word
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    class_word_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_word  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/stu_back.sv =====
module stu_back
    import stu_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BASE_W-1:0] number_base,
    input  logic              avail,
    input  class_word_t       entry,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output result_word_t      res_word
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic [BASE_W-1:0]       abase_reg;
    logic [BASE_W-1:0]       abase_next;
    logic [COUNT_WIDTH-1:0]  cnt_reg;
    logic [COUNT_WIDTH-1:0]  cnt_next;
    logic                    done_reg;
    logic                    out_valid_reg;
    result_word_t            out_word_reg;
    result_word_t            out_word_next;

    logic [COUNT_WIDTH-1:0]  cnt_inc;
    logic [BASE_W-1:0]       eff_base;
    logic [VALUE_WIDTH-1:0]  mac;
    logic                    taken;
    logic                    do_start;
    logic                    load_out;
    logic [VALUE_WIDTH-1:0]  emit_value;
    logic [COUNT_WIDTH-1:0]  emit_count;

    assign pop       = avail && (!out_valid_reg || res_ready);
    assign load_out  = pop && !done_reg && !(taken && !entry.is_last);
    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;
    assign cnt_inc   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign eff_base  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
    assign mac       = (acc_reg * VALUE_WIDTH'(abase_reg)) + VALUE_WIDTH'(entry.digit);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        abase_next = abase_reg;
        cnt_next   = cnt_reg;
        taken      = 1'b0;
        do_start   = 1'b0;
        case (phase_reg)
            PH_SPACE:
            begin
                if (entry.is_space)
                begin
                    cnt_next = cnt_inc;
                    taken    = 1'b1;
                end
                else if (entry.is_plus)
                begin
                    phase_next = PH_SIGN;
                    cnt_next   = cnt_inc;
                    taken      = 1'b1;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            PH_SIGN:
            begin
                do_start = 1'b1;
            end
            PH_ZERO, PH_X, PH_DIGITS:
            begin
                if (phase_reg == PH_ZERO && entry.is_x)
                begin
                    abase_next = BASE_HEX;
                    phase_next = PH_X;
                    cnt_next   = cnt_inc;
                    taken      = 1'b1;
                end
                else if (entry.is_digit && (entry.digit < abase_reg))
                begin
                    acc_next   = (phase_reg == PH_DIGITS) ? mac : VALUE_WIDTH'(entry.digit);
                    phase_next = PH_DIGITS;
                    cnt_next   = cnt_inc;
                    taken      = 1'b1;
                end
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase

        if (do_start)
        begin
            if ((number_base == BASE_AUTO || number_base == BASE_HEX) && entry.is_zero)
            begin
                abase_next = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                acc_next   = '0;
                phase_next = PH_ZERO;
                cnt_next   = cnt_inc;
                taken      = 1'b1;
            end
            else if (eff_base >= BASE_MIN && eff_base <= BASE_MAX)
            begin
                abase_next = eff_base;
                if (entry.is_digit && (entry.digit < eff_base))
                begin
                    acc_next   = VALUE_WIDTH'(entry.digit);
                    phase_next = PH_DIGITS;
                    cnt_next   = cnt_inc;
                    taken      = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        emit_value = '0;
        emit_count = '0;
        case (phase_next)
            PH_ZERO:
            begin
                emit_count = cnt_next;
            end
            PH_X:
            begin
                if (cnt_next == CNT_MAX)
                begin
                    emit_count = CNT_MAX;
                end
                else if (cnt_next != '0)
                begin
                    emit_count = cnt_next - 1'b1;
                end
            end
            PH_DIGITS:
            begin
                emit_value = acc_next;
                emit_count = cnt_next;
            end
            default:
            begin
                emit_value = '0;
            end
        endcase
        out_word_next.value          = OUT_VALUE_W'(emit_value);
        out_word_next.consumed_count = OUT_COUNT_W'(emit_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            abase_reg     <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (entry.is_last)
                begin
                    phase_reg <= PH_SPACE;
                    acc_reg   <= '0;
                    abase_reg <= '0;
                    cnt_reg   <= '0;
                    done_reg  <= 1'b0;
                end
                else if (!done_reg)
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    abase_reg <= abase_next;
                    cnt_reg   <= cnt_next;
                    done_reg  <= !taken;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_word_reg <= out_word_next;
        end
    end

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && done_reg && !entry.is_last) |=> done_reg)
        else $error("stop flag dropped before end of string");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && entry.is_last) |=> (phase_reg == PH_SPACE && !done_reg && cnt_reg == '0))
        else $error("string state not cleared after last word");

    a_digits_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS || phase_reg == PH_ZERO) |-> (cnt_reg != '0))
        else $error("digit phase with zero count");

    a_hex_after_x: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_X) |-> (abase_reg == BASE_HEX))
        else $error("prefix phase without base 16");

    a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && done_reg) |=> !(out_valid_reg && !$past(out_valid_reg && !res_ready)
                                && $rose(out_valid_reg)))
        else $error("result after stop");

endmodule

// ===== rtl/string_to_unsigned_parser_core.sv =====
// channel  | handshake                       | payload
// char     | char_valid / char_ready         | char_word (char_code, is_last)
// res      | res_valid / res_ready           | res_word (value, consumed_count)
// config   | psel penable pwrite pready      | paddr, pwdata, prdata
//
// one character per cycle sustained while res_ready lets the back end drain the queue; a result word
// is offered from the output register once the character that ends its number has passed through the queue
// the back end holds one multiply-add of the accumulator by the base per cycle
// a two-word queue splits the classifier from the back end, which stalls only on res_ready
// rst_n clears the base register to automatic detection and the string state
module string_to_unsigned_parser_core
    import stu_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  char_word_t        char_word,
    output logic              res_valid,
    input  logic              res_ready,
    output result_word_t      res_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [BASE_W-1:0] number_base_reg;
    logic              queue_full;
    logic              push;
    class_word_t       push_word;
    logic              pop;
    logic              not_empty;
    class_word_t       pop_word;
    logic              reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_NUMBER_BASE);
    assign prdata  = reg_hit ? DATA_W'(number_base_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_AUTO;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            number_base_reg <= pwdata[BASE_W-1:0];
        end
    end

    stu_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    stu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_word  (pop_word)
    );

    stu_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_base (number_base_reg),
        .avail       (not_empty),
        .entry       (pop_word),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_word    (res_word)
    );

endmodule
